// ===== design/gfba_pkg.sv =====
// shared widths, codes and controller/datapath interface types for the free-block allocator
package gfba_pkg;

	// fixed field widths
	localparam int BLK_W = 10;
	localparam int CNT_W = 11;
	localparam int OP_W  = 2;
	localparam int ST_W  = 2;

	// parameter defaults
	localparam int NUM_BLOCKS_DEF = 1024;
	localparam int GROUP_SIZE_DEF = 64;

	// total_blocks after reset
	localparam logic [CNT_W-1:0] TOTAL_RESET = CNT_W'(1024);

	// operation codes
	localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
	localparam logic [OP_W-1:0] OP_FORMAT = 2'd2;

	// status codes
	localparam logic [ST_W-1:0] ST_OK       = 2'd0;
	localparam logic [ST_W-1:0] ST_NOFREE   = 2'd1;
	localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd2;

	// commands from controller to datapath
	typedef struct packed {
		logic            latch;       // capture block number, clear result
		logic            set_status;
		logic [ST_W-1:0] status_code;
		logic            pop;         // read top of stack, decrement counts
		logic            take;        // capture popped block as granted
		logic            load_base;   // compute group base, clear copy index
		logic            base_src_granted;
		logic            refill_step; // group store -> stack, one entry
		logic            spill_step;  // stack -> group store, one entry
		logic            set_full;
		logic            clr_sc;
		logic            push;
		logic            fmt_mode;
		logic            fmt_init;
		logic            fc_load;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic fc_zero;
		logic sc_zero;
		logic sc_full;
		logic fc_ge_eff;
		logic cnt_zero;
		logic k_last;
	} sts_t;

endpackage

// ===== design/gfba_ram.sv =====
// generic simple dual-port ram with registered read
module gfba_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/gfba_datapath.sv =====
// allocator datapath: counts, free stack, group store and copy engine
module gfba_datapath import gfba_pkg::*; #(
	parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
	parameter int GROUP_SIZE = GROUP_SIZE_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output sts_t             sts,
	input  logic [BLK_W-1:0] block_number,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	output logic [BLK_W-1:0] granted_block,
	output logic [ST_W-1:0]  status,
	output logic [CNT_W-1:0] blocks_free
);

	localparam int KW   = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
	localparam int SCW  = $clog2(GROUP_SIZE + 1);
	localparam int GW   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int GDEP = NUM_BLOCKS * GROUP_SIZE;
	localparam int AW   = $clog2(GDEP);
	localparam int MODW = GW + 4;

	localparam logic [MODW-1:0]  NB_M   = MODW'(NUM_BLOCKS);
	localparam logic [AW-1:0]    GS_A   = AW'(GROUP_SIZE);
	localparam logic [SCW-1:0]   GS_SC  = SCW'(GROUP_SIZE);
	localparam logic [KW-1:0]    K_LAST = KW'(GROUP_SIZE - 1);
	localparam logic [CNT_W-1:0] NB_CAP =
		(NUM_BLOCKS > ((1 << CNT_W) - 1)) ? CNT_W'((1 << CNT_W) - 1) : CNT_W'(NUM_BLOCKS);

	// block number reduced modulo NUM_BLOCKS, four conditional subtracts
	function automatic logic [GW-1:0] grp_index(input logic [CNT_W-1:0] v);
		logic [MODW-1:0] r;
		r = MODW'(v);
		for (int j = 3; j >= 0; j--) begin
			if (r >= (NB_M << j)) begin
				r = r - (NB_M << j);
			end
		end
		return GW'(r);
	endfunction

	logic [CNT_W-1:0] total_q;
	logic [CNT_W-1:0] fc_q;
	logic [SCW-1:0]   sc_q;
	logic [CNT_W-1:0] cnt_q;
	logic [KW-1:0]    k_q;
	logic             spill_wr_s1;
	logic             refill_wr_s1;
	logic [KW-1:0]    k_s1;
	logic [BLK_W-1:0] blk_q;
	logic [BLK_W-1:0] granted_q;
	logic [ST_W-1:0]  status_q;
	logic [AW-1:0]    base_q;

	logic [CNT_W-1:0] eff;
	logic [CNT_W-1:0] push_val;
	logic [CNT_W-1:0] base_src;
	logic [SCW-1:0]   sc_dec;

	logic             stk_we;
	logic [KW-1:0]    stk_waddr;
	logic [BLK_W-1:0] stk_wdata;
	logic [KW-1:0]    stk_raddr;
	logic [BLK_W-1:0] stk_rdata;
	logic [AW-1:0]    grp_waddr;
	logic [AW-1:0]    grp_raddr;
	logic [BLK_W-1:0] grp_rdata;

	// effective list size and value to push
	assign eff      = (total_q > NB_CAP) ? NB_CAP : total_q;
	assign push_val = cmd.fmt_mode ? (cnt_q - CNT_W'(1)) : CNT_W'(blk_q);
	assign base_src = cmd.base_src_granted ? CNT_W'(stk_rdata) : push_val;
	assign sc_dec   = sc_q - SCW'(1);

	// status to controller
	assign sts.fc_zero   = (fc_q == '0);
	assign sts.sc_zero   = (sc_q == '0);
	assign sts.sc_full   = (sc_q == GS_SC);
	assign sts.fc_ge_eff = (fc_q >= eff);
	assign sts.cnt_zero  = (cnt_q == '0);
	assign sts.k_last    = (k_q == K_LAST);

	// free stack port selection
	always_comb begin
		stk_we    = 1'b0;
		stk_waddr = '0;
		stk_wdata = '0;
		if (cmd.fmt_init) begin
			stk_we = 1'b1;
		end else if (cmd.push) begin
			stk_we    = 1'b1;
			stk_waddr = sc_q[KW-1:0];
			stk_wdata = push_val[BLK_W-1:0];
		end else if (refill_wr_s1) begin
			stk_we    = 1'b1;
			stk_waddr = k_s1;
			stk_wdata = grp_rdata;
		end
		stk_raddr = cmd.pop ? sc_dec[KW-1:0] : k_q;
	end

	// group store addresses
	assign grp_raddr = base_q + AW'(k_q);
	assign grp_waddr = base_q + AW'(k_s1);

	gfba_ram #(
		.WIDTH (BLK_W),
		.DEPTH (GROUP_SIZE)
	) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	gfba_ram #(
		.WIDTH (BLK_W),
		.DEPTH (GDEP)
	) u_group (
		.clk   (clk),
		.we    (spill_wr_s1),
		.waddr (grp_waddr),
		.wdata (stk_rdata),
		.raddr (grp_raddr),
		.rdata (grp_rdata)
	);

	// control registers: config, counts, copy index, write pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q      <= TOTAL_RESET;
			fc_q         <= '0;
			sc_q         <= '0;
			cnt_q        <= '0;
			k_q          <= '0;
			spill_wr_s1  <= 1'b0;
			refill_wr_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				total_q <= cfg_wdata;
			end
			spill_wr_s1  <= cmd.spill_step;
			refill_wr_s1 <= cmd.refill_step;
			if (cmd.load_base) begin
				k_q <= '0;
			end else if (cmd.spill_step || cmd.refill_step) begin
				k_q <= k_q + KW'(1);
			end
			if (cmd.pop) begin
				sc_q <= sc_dec;
				fc_q <= fc_q - CNT_W'(1);
			end else if (cmd.push) begin
				sc_q <= sc_q + SCW'(1);
				if (cmd.fmt_mode) begin
					cnt_q <= cnt_q - CNT_W'(1);
				end else begin
					fc_q <= fc_q + CNT_W'(1);
				end
			end else if (cmd.fmt_init) begin
				sc_q  <= SCW'(1);
				cnt_q <= eff;
			end else if (cmd.set_full) begin
				sc_q <= GS_SC;
			end else if (cmd.clr_sc) begin
				sc_q <= '0;
			end else if (cmd.fc_load) begin
				fc_q <= eff;
			end
		end
	end

	// result and address payload
	always_ff @(posedge clk) begin
		k_s1 <= k_q;
		if (cmd.latch) begin
			blk_q     <= block_number;
			granted_q <= '0;
			status_q  <= ST_OK;
		end
		if (cmd.take) begin
			granted_q <= stk_rdata;
		end
		if (cmd.set_status) begin
			status_q <= cmd.status_code;
		end
		if (cmd.load_base) begin
			base_q <= AW'(grp_index(base_src)) * GS_A;
		end
	end

	assign granted_block = granted_q;
	assign status        = status_q;
	assign blocks_free   = fc_q;

endmodule

// ===== design/gfba_ctrl.sv =====
// allocator controller: sequences allocate, free, spill, refill and format
module gfba_ctrl import gfba_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [OP_W-1:0] op,
	output logic            busy,
	output logic            done,
	output cmd_t            cmd,
	input  sts_t            sts
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_TAKE,
		S_REFILL,
		S_REFILL_END,
		S_SPILL,
		S_SPILL_END,
		S_PUSH,
		S_FMT,
		S_RESP
	} state_t;

	state_t          state_q;
	state_t          state_nxt;
	logic [OP_W-1:0] op_q;

	// next state and datapath commands
	always_comb begin
		state_nxt    = state_q;
		cmd          = '0;
		cmd.fmt_mode = (op_q == OP_FORMAT);
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_nxt = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (op_q)
					OP_ALLOC: begin
						if (sts.fc_zero || sts.sc_zero) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = ST_NOFREE;
							state_nxt       = S_RESP;
						end else begin
							cmd.pop   = 1'b1;
							state_nxt = S_TAKE;
						end
					end
					OP_FREE: begin
						if (sts.fc_ge_eff) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = ST_OVERFLOW;
							state_nxt       = S_RESP;
						end else if (sts.sc_full) begin
							cmd.load_base = 1'b1;
							state_nxt     = S_SPILL;
						end else begin
							cmd.push  = 1'b1;
							state_nxt = S_RESP;
						end
					end
					OP_FORMAT: begin
						cmd.fmt_init = 1'b1;
						state_nxt    = S_FMT;
					end
					default: begin
						state_nxt = S_RESP;
					end
				endcase
			end
			// popped word is on the stack read port
			S_TAKE: begin
				cmd.take = 1'b1;
				if (sts.sc_zero && !sts.fc_zero) begin
					cmd.load_base        = 1'b1;
					cmd.base_src_granted = 1'b1;
					state_nxt            = S_REFILL;
				end else begin
					state_nxt = S_RESP;
				end
			end
			S_REFILL: begin
				cmd.refill_step = 1'b1;
				if (sts.k_last) begin
					state_nxt = S_REFILL_END;
				end
			end
			S_REFILL_END: begin
				cmd.set_full = 1'b1;
				state_nxt    = S_RESP;
			end
			S_SPILL: begin
				cmd.spill_step = 1'b1;
				if (sts.k_last) begin
					state_nxt = S_SPILL_END;
				end
			end
			S_SPILL_END: begin
				cmd.clr_sc = 1'b1;
				state_nxt  = S_PUSH;
			end
			S_PUSH: begin
				cmd.push  = 1'b1;
				state_nxt = (op_q == OP_FORMAT) ? S_FMT : S_RESP;
			end
			// format: push blocks from the top down, spilling full groups
			S_FMT: begin
				if (sts.cnt_zero) begin
					cmd.fc_load = 1'b1;
					state_nxt   = S_RESP;
				end else if (sts.sc_full) begin
					cmd.load_base = 1'b1;
					state_nxt     = S_SPILL;
				end else begin
					cmd.push = 1'b1;
				end
			end
			S_RESP: begin
				state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// state and captured opcode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_ALLOC;
		end else begin
			state_q <= state_nxt;
			if (state_q == S_IDLE && start) begin
				op_q <= op;
			end
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_RESP);

endmodule

// ===== design/grouped_free_block_allocator.sv =====
// top level of the grouped free-block allocator
//
//  channel   handshake            word
//  command   start / busy         op, block_number
//  result    done (one cycle)     granted_block, status, blocks_free
//  config    cfg_we               cfg_wdata (total_blocks)
//
// A command is taken when start is high and busy low; its result shows on done
// for one cycle. A plain free passes through the controller's dispatch and result
// states; a plain allocate also has a take state for the stack ram's registered
// read. An allocate that empties the stack while free blocks remain refills it from
// the group store, and a free onto a full stack first spills it to the group store
// (one entry per cycle through the group store port); format pushes each block and
// spills each full group. Reset clears counts only: both stores come up unwritten,
// no clearing pass. The receiver cannot hold results off.
module grouped_free_block_allocator import gfba_pkg::*; #(
	parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
	parameter int GROUP_SIZE = GROUP_SIZE_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [OP_W-1:0]  op,
	input  logic [BLK_W-1:0] block_number,
	output logic             done,
	output logic [BLK_W-1:0] granted_block,
	output logic [ST_W-1:0]  status,
	output logic [CNT_W-1:0] blocks_free,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata
);

	cmd_t cmd;
	sts_t sts;

	// sequencing
	gfba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.sts    (sts)
	);

	// storage and arithmetic
	gfba_datapath #(
		.NUM_BLOCKS (NUM_BLOCKS),
		.GROUP_SIZE (GROUP_SIZE)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.block_number  (block_number),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.granted_block (granted_block),
		.status        (status),
		.blocks_free   (blocks_free)
	);

endmodule
